// ===== rtl/core/tlnef_pkg.sv =====
package tlnef_pkg;

	// line number width in decimal digits
	localparam int NumDigits = 6;
	localparam int BcdW      = 4 * NumDigits;

	// sequence positions: digits, tab, prefix, final byte
	localparam int SeqLen = NumDigits + 3;
	localparam int PosW   = $clog2(SeqLen);

	localparam logic [PosW-1:0] POS_FIRST = PosW'(0);
	localparam logic [PosW-1:0] POS_TAB   = PosW'(NumDigits);
	localparam logic [PosW-1:0] POS_PRE   = PosW'(NumDigits + 1);
	localparam logic [PosW-1:0] POS_FIN   = PosW'(NumDigits + 2);

	// configuration register indexes
	localparam int CfgIdxW = 3;
	typedef enum logic [CfgIdxW-1:0] {
		CFG_NUMBER_ALL       = 3'd0,
		CFG_NUMBER_NONBLANK  = 3'd1,
		CFG_SQUEEZE_BLANK    = 3'd2,
		CFG_SHOW_ENDS        = 3'd3,
		CFG_SHOW_TABS        = 3'd4,
		CFG_SHOW_NONPRINTING = 3'd5
	} cfg_idx_t;

	// character codes
	localparam logic [7:0] CHR_TAB    = 8'h09;
	localparam logic [7:0] CHR_NL     = 8'h0a;
	localparam logic [7:0] CHR_SPACE  = 8'h20;
	localparam logic [7:0] CHR_DOLLAR = 8'h24;
	localparam logic [7:0] CHR_ZERO   = 8'h30;
	localparam logic [7:0] CHR_QUEST  = 8'h3f;
	localparam logic [7:0] CHR_I      = 8'h49;
	localparam logic [7:0] CHR_CARET  = 8'h5e;
	localparam logic [7:0] CHR_DEL    = 8'h7f;
	localparam logic [7:0] CTRL_SHIFT = 8'h40;

	localparam logic [1:0] BLANK_MAX = 2'd2;
	localparam logic [3:0] BCD_NINE  = 4'd9;

	// one count up in bcd, holding at all nines
	function automatic logic [BcdW-1:0] bcd_inc(input logic [BcdW-1:0] v);
		logic [BcdW-1:0] r;
		logic            carry;
		r     = v;
		carry = 1'b1;
		for (int d = 0; d < NumDigits; d++) begin
			if (carry) begin
				if (v[4*d +: 4] < BCD_NINE) begin
					r[4*d +: 4] = v[4*d +: 4] + 4'd1;
					carry       = 1'b0;
				end else begin
					r[4*d +: 4] = 4'd0;
				end
			end
		end
		if (carry) begin
			r = v;
		end
		return r;
	endfunction

	// every digit in 0..9
	function automatic logic bcd_valid(input logic [BcdW-1:0] v);
		logic ok;
		ok = 1'b1;
		for (int d = 0; d < NumDigits; d++) begin
			if (v[4*d +: 4] > BCD_NINE) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

// ===== rtl/core/text_line_number_escape_filter_core.sv =====
// channel | direction | transaction                | payload
// s_      | in        | one raw text byte          | s_tdata[7:0] in_byte
// m_      | out       | one rendered byte          | m_tdata[7:0] out_byte, m_tlast last_of_run
// cfg_    | in        | one register write         | cfg_index register, cfg_data bit 0 value
//
// each input byte is decoded combinationally into a byte sequence held in the s1 register;
// the sequence drains one byte a cycle into the m_ output register unless m_ stalls;
// 1 to 9 bytes per input byte (line number: 7, caret or dollar prefix: 1, final: 1).
// a dropped blank line never loads s1; plain bytes sustain one per cycle if m_ is ready.
// reset clears the control registers and loads line number one; no clearing pass.
// m_tready low holds the output register and, once s1 is full, holds s_tready low.
module text_line_number_escape_filter_core
	import tlnef_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] in_byte
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,   // [7:0] out_byte
	output logic               m_tlast,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic               cfg_data
);

	// configuration registers
	logic number_all_q, number_nonblank_q, squeeze_q;
	logic show_ends_q, show_tabs_q, show_np_q;

	// stream state
	logic            after_nl_q;
	logic [1:0]      blank_run_q;
	logic [BcdW-1:0] count_q;

	// sequence register and output register
	logic            valid_s1;
	logic [PosW-1:0] pos_q;
	logic            pre_en_s1;
	logic [7:0]      seq_s1 [SeqLen];
	logic            out_valid_s2;
	logic [7:0]      out_byte_s2;
	logic            out_last_s2;

	// decode signals
	logic            acc, load_s1, out_load, s1_step, s1_done;
	logic            is_nl, sq_hit, drop, num_en, pre_en, lead;
	logic [1:0]      blank_inc, blank_nxt;
	logic [7:0]      pre_chr, fin_chr;
	logic [3:0]      dig;
	logic [7:0]      num_chr [NumDigits];
	logic [PosW-1:0] pos_start, pos_next;

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_s2;
	assign m_tdata   = out_byte_s2;
	assign m_tlast   = out_last_s2;

	// handshake
	assign acc      = s_tvalid && s_tready;
	assign load_s1  = acc && !drop;
	assign out_load = !out_valid_s2 || m_tready;
	assign s1_step  = valid_s1 && out_load;
	assign s1_done  = s1_step && (pos_q == POS_FIN);
	assign s_tready = !valid_s1 || s1_done;

	// decode the input byte
	always_comb begin
		is_nl     = (s_tdata == CHR_NL);
		sq_hit    = squeeze_q && is_nl && after_nl_q;
		blank_inc = (blank_run_q < BLANK_MAX) ? blank_run_q + 2'd1 : blank_run_q;
		blank_nxt = sq_hit ? blank_inc : 2'd0;
		drop      = sq_hit && (blank_inc > 2'd1);
		num_en    = after_nl_q &&
			((number_all_q && !number_nonblank_q) || (number_nonblank_q && !is_nl));
		pre_en  = 1'b0;
		pre_chr = CHR_CARET;
		fin_chr = s_tdata;
		if (show_tabs_q && s_tdata == CHR_TAB) begin
			pre_en  = 1'b1;
			fin_chr = CHR_I;
		end else if (show_ends_q && is_nl) begin
			pre_en  = 1'b1;
			pre_chr = CHR_DOLLAR;
		end
		if (show_np_q) begin
			fin_chr = {1'b0, fin_chr[6:0]};
			if (fin_chr < CHR_TAB || (fin_chr > CHR_NL && fin_chr < CHR_SPACE)) begin
				pre_en  = 1'b1;
				pre_chr = CHR_CARET;
				fin_chr = fin_chr + CTRL_SHIFT;
			end else if (fin_chr == CHR_DEL) begin
				pre_en  = 1'b1;
				pre_chr = CHR_CARET;
				fin_chr = CHR_QUEST;
			end
		end
		// digits with leading spaces, units digit always shown
		lead = 1'b1;
		dig  = 4'd0;
		for (int d = NumDigits - 1; d >= 0; d--) begin
			dig = count_q[4*d +: 4];
			if (lead && dig == 4'd0 && d > 0) begin
				num_chr[d] = CHR_SPACE;
			end else begin
				lead       = 1'b0;
				num_chr[d] = CHR_ZERO + {4'd0, dig};
			end
		end
		pos_start = num_en ? POS_FIRST : (pre_en ? POS_PRE : POS_FIN);
	end

	// next position in the sequence
	always_comb begin
		if (pos_q < POS_TAB) begin
			pos_next = pos_q + PosW'(1);
		end else if (pos_q == POS_TAB) begin
			pos_next = pre_en_s1 ? POS_PRE : POS_FIN;
		end else begin
			pos_next = POS_FIN;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_all_q      <= 1'b0;
			number_nonblank_q <= 1'b0;
			squeeze_q         <= 1'b0;
			show_ends_q       <= 1'b0;
			show_tabs_q       <= 1'b0;
			show_np_q         <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_NUMBER_ALL:       number_all_q      <= cfg_data;
				CFG_NUMBER_NONBLANK:  number_nonblank_q <= cfg_data;
				CFG_SQUEEZE_BLANK:    squeeze_q         <= cfg_data;
				CFG_SHOW_ENDS:        show_ends_q       <= cfg_data;
				CFG_SHOW_TABS:        show_tabs_q       <= cfg_data;
				CFG_SHOW_NONPRINTING: show_np_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	// stream state update on each input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_nl_q  <= 1'b1;
			blank_run_q <= 2'd0;
			count_q     <= BcdW'(1);
		end else if (acc) begin
			blank_run_q <= blank_nxt;
			if (!drop) begin
				after_nl_q <= (fin_chr == CHR_NL);
				if (num_en) begin
					count_q <= bcd_inc(count_q);
				end
			end
		end
	end

	// sequence register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_q    <= POS_FIN;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
			pos_q    <= pos_start;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end else if (s1_step) begin
			pos_q <= pos_next;
		end
	end

	// sequence register payload
	always_ff @(posedge clk) begin
		if (load_s1) begin
			pre_en_s1 <= pre_en;
			for (int p = 0; p < NumDigits; p++) begin
				seq_s1[p] <= num_chr[NumDigits - 1 - p];
			end
			seq_s1[NumDigits]     <= CHR_TAB;
			seq_s1[NumDigits + 1] <= pre_chr;
			seq_s1[NumDigits + 2] <= fin_chr;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_load) begin
			out_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_step) begin
			out_byte_s2 <= seq_s1[pos_q];
			out_last_s2 <= (pos_q == POS_FIN);
		end
	end

	// checks
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (pos_q <= POS_FIN))
		else $error("sequence position out of range");

	a_count_bcd: assert property (@(posedge clk) disable iff (!arst_n)
		bcd_valid(count_q))
		else $error("line counter holds a non-decimal digit");

	a_mid_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_step && pos_q != POS_FIN) |=> (m_tvalid && !m_tlast))
		else $error("tlast raised before the final byte");

	a_drop_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && drop && !valid_s1) |=> !valid_s1)
		else $error("dropped blank line produced output");

	a_load_fills: assert property (@(posedge clk) disable iff (!arst_n)
		load_s1 |=> valid_s1)
		else $error("accepted byte lost");

endmodule

// ===== dv/text_line_number_escape_filter_core_tb.sv =====
`timescale 1ns / 1ps

module text_line_number_escape_filter_core_tb;
	import tlnef_pkg::*;

	localparam int RandItems   = 360;
	localparam int PhaseItems  = 45;
	localparam int SettleCycles = 8;
	localparam int StallCycles = 64;
	localparam int StallAfter  = 120;
	localparam int CycleLimit  = 200000;
	localparam int ReportMax   = 10;
	localparam int NumRegs     = CFG_SHOW_NONPRINTING + 1;

	// writes to these indexes must be ignored by the block
	localparam logic [CfgIdxW-1:0] CfgSpareLo = CfgIdxW'(CFG_SHOW_NONPRINTING + 1);
	localparam logic [CfgIdxW-1:0] CfgSpareHi = '1;

	typedef enum logic {
		ROW_BYTE,
		ROW_CFG
	} row_kind_t;

	// one directed step: a text byte or a register write
	typedef struct {
		row_kind_t          kind;
		logic [7:0]         value;
		logic [CfgIdxW-1:0] idx;
		bit                 typed;
		string              txt;
	} stim_row_t;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} out_beat_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [7:0]         m_tdata;
	logic               m_tlast;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic               cfg_data;

	// shadow of the filter state
	logic [CFG_SHOW_NONPRINTING:0] reg_on;
	logic                          line_start;
	logic [1:0]                    blank_cnt;
	logic [BcdW-1:0]               line_bcd;

	logic [7:0] beat_buf[$];
	out_beat_t  rendered_q[$];

	int  tx_gap_max;
	int  rx_gap_max;
	int  text_sent;
	int  err_count;
	int  cycle_cnt;
	logic hold_rx;

	stim_row_t dir_rows [37];

	text_line_number_escape_filter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// decimal line counter step, sticks at all nines
	function automatic logic [BcdW-1:0] count_up(input logic [BcdW-1:0] v);
		logic [BcdW-1:0] r;
		r = v;
		for (int d = 0; d < NumDigits; d++) begin
			if (r[4*d +: 4] != 4'd9) begin
				r[4*d +: 4] = r[4*d +: 4] + 4'd1;
				return r;
			end
			r[4*d +: 4] = 4'd0;
		end
		return v;
	endfunction

	// bytes rendered for one input byte, left in beat_buf
	function automatic void render_byte(input logic [7:0] raw);
		logic [7:0] c;
		logic       is_nl;
		logic       lead;
		logic [3:0] dig;
		c     = raw;
		is_nl = (raw == CHR_NL);
		lead  = 1'b1;
		beat_buf.delete();
		// blank line squeeze
		if (reg_on[CFG_SQUEEZE_BLANK] && is_nl && line_start) begin
			if (blank_cnt < BLANK_MAX)
				blank_cnt = blank_cnt + 2'd1;
			if (blank_cnt > 2'd1)
				return;
		end else begin
			blank_cnt = 2'd0;
		end
		// line number prefix
		if (line_start && ((reg_on[CFG_NUMBER_ALL] && !reg_on[CFG_NUMBER_NONBLANK]) ||
				(reg_on[CFG_NUMBER_NONBLANK] && !is_nl))) begin
			for (int d = NumDigits - 1; d >= 0; d--) begin
				dig = line_bcd[4*d +: 4];
				if (lead && dig == 4'd0 && d > 0) begin
					beat_buf.push_back(CHR_SPACE);
				end else begin
					lead = 1'b0;
					beat_buf.push_back(CHR_ZERO + 8'(dig));
				end
			end
			beat_buf.push_back(CHR_TAB);
			line_bcd = count_up(line_bcd);
		end
		// visible tab and line end look at the raw byte
		if (reg_on[CFG_SHOW_TABS] && c == CHR_TAB) begin
			beat_buf.push_back(CHR_CARET);
			c = CHR_I;
		end
		if (reg_on[CFG_SHOW_ENDS] && is_nl)
			beat_buf.push_back(CHR_DOLLAR);
		// caret escapes on the stripped byte
		if (reg_on[CFG_SHOW_NONPRINTING]) begin
			c[7] = 1'b0;
			if (c < CHR_TAB || (c > CHR_NL && c < CHR_SPACE)) begin
				beat_buf.push_back(CHR_CARET);
				c = c + CTRL_SHIFT;
			end else if (c == CHR_DEL) begin
				beat_buf.push_back(CHR_CARET);
				c = CHR_QUEST;
			end
		end
		beat_buf.push_back(c);
		line_start = (c == CHR_NL);
	endfunction

	function automatic void flag_error(input string msg);
		err_count++;
		if (err_count <= ReportMax)
			$display("mismatch: %s", msg);
	endfunction

	// random text byte, mostly printable
	function automatic logic [7:0] pick_char();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return 8'($urandom_range(CHR_SPACE, CHR_DEL - 1));
		else if (sel < 63)
			return CHR_TAB;
		else if (sel < 71)
			return 8'($urandom_range(0, CHR_SPACE - 1));
		else if (sel < 75)
			return CHR_DEL;
		else if (sel < 90)
			return 8'($urandom_range(8'h80, 8'hff));
		return 8'($urandom_range(0, 255));
	endfunction

	// one input transaction, then record what it should render
	task automatic send_byte(input logic [7:0] b, input bit typed, input string txt);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		render_byte(b);
		if (typed) begin
			beat_buf.delete();
			for (int i = 0; i < txt.len(); i++)
				beat_buf.push_back(txt[i]);
		end
		foreach (beat_buf[i])
			rendered_q.push_back(out_beat_t'{beat_buf[i], i == beat_buf.size() - 1});
	endtask

	// register write transaction, valid is left high for back to back writes
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= CFG_SHOW_NONPRINTING)
			reg_on[idx] = val;
	endtask

	// drain every pending byte and let the block settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (rendered_q.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// a text line: body then a line end, sometimes blank or broken
	task automatic send_line();
		int len;
		len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
		for (int k = 0; k < len; k++)
			send_byte(pick_char(), 1'b0, "");
		if ($urandom_range(0, 9) == 0)
			send_byte(8'($urandom_range(0, 255)), 1'b0, "");
		else
			send_byte(($urandom_range(0, 9) == 0) ? (CHR_NL | 8'h80) : CHR_NL, 1'b0, "");
		text_sent += len + 1;
	endtask

	// output side: random ready gaps plus one long hold off
	initial begin
		int gap;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = $urandom_range(0, rx_gap_max);
			if (gap != 0 || hold_rx) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
				while (hold_rx) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// long receiver stall so the block backs up into its input
	initial begin
		hold_rx <= 1'b0;
		wait (text_sent >= StallAfter);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (StallCycles) @(posedge clk);
		hold_rx <= 1'b0;
	end

	// compare each output transaction with the oldest pending byte
	always @(posedge clk) begin : out_check
		out_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (rendered_q.size() == 0) begin
				flag_error($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
			end else begin
				want = rendered_q.pop_front();
				if (m_tdata !== want.ch || m_tlast !== want.last)
					flag_error($sformatf("byte exp %02h got %02h, last exp %0b got %0b",
						want.ch, m_tdata, want.last, m_tlast));
			end
		end
	end

	// watchdog
	initial cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CycleLimit) begin
			$display("text_line_number_escape_filter_core_tb: errors");
			$finish;
		end
	end

	// main sequence
	initial begin
		logic [CFG_SHOW_NONPRINTING:0] phase_bits;
		bit prev_cfg;
		int phase;
		int target;

		arst_n     <= 1'b0;
		s_tvalid   <= 1'b0;
		s_tdata    <= 8'h00;
		cfg_valid  <= 1'b0;
		cfg_index  <= CFG_NUMBER_ALL;
		cfg_data   <= 1'b0;
		reg_on     = '0;
		line_start = 1'b1;
		blank_cnt  = 2'd0;
		line_bcd   = BcdW'(1);
		tx_gap_max = 3;
		rx_gap_max = 3;
		text_sent  = 0;
		err_count  = 0;

		dir_rows = '{
			// reset settings: bytes pass through untouched
			'{ROW_BYTE, 8'h41, '0, 1'b1, "A"},
			'{ROW_BYTE, 8'h00, '0, 1'b0, ""},
			'{ROW_BYTE, 8'hff, '0, 1'b1, "\377"},
			'{ROW_BYTE, 8'h0a, '0, 1'b1, "\n"},
			// all on but non-blank numbering, spare indexes must do nothing
			'{ROW_CFG, 8'h01, CFG_NUMBER_ALL, 1'b0, ""},
			'{ROW_CFG, 8'h01, CFG_SQUEEZE_BLANK, 1'b0, ""},
			'{ROW_CFG, 8'h01, CFG_SHOW_ENDS, 1'b0, ""},
			'{ROW_CFG, 8'h01, CFG_SHOW_TABS, 1'b0, ""},
			'{ROW_CFG, 8'h01, CFG_SHOW_NONPRINTING, 1'b0, ""},
			'{ROW_CFG, 8'h01, CfgSpareLo, 1'b0, ""},
			'{ROW_CFG, 8'h00, CfgSpareHi, 1'b0, ""},
			// numbered tab line gives the longest expansion
			'{ROW_BYTE, 8'h09, '0, 1'b1, "     1\t^I"},
			'{ROW_BYTE, 8'h0a, '0, 1'b1, "$\n"},
			'{ROW_BYTE, 8'h0a, '0, 1'b1, "     2\t$\n"},
			// repeated blank lines are dropped
			'{ROW_BYTE, 8'h0a, '0, 1'b1, ""},
			'{ROW_BYTE, 8'h0a, '0, 1'b1, ""},
			'{ROW_BYTE, 8'h7f, '0, 1'b1, "     3\t^?"},
			// high tab and high newline skip the tab and end marks
			'{ROW_BYTE, 8'h89, '0, 1'b1, "\t"},
			'{ROW_BYTE, 8'h8a, '0, 1'b1, "\n"},
			'{ROW_BYTE, 8'h01, '0, 1'b1, "     4\t^A"},
			'{ROW_BYTE, 8'hc1, '0, 1'b0, ""},
			'{ROW_BYTE, 8'h9f, '0, 1'b1, "^_"},
			'{ROW_BYTE, 8'h80, '0, 1'b1, "^@"},
			'{ROW_BYTE, 8'hff, '0, 1'b1, "^?"},
			// non-blank numbering wins over number all
			'{ROW_CFG, 8'h01, CFG_NUMBER_NONBLANK, 1'b0, ""},
			'{ROW_CFG, 8'h00, CFG_SQUEEZE_BLANK, 1'b0, ""},
			'{ROW_CFG, 8'h00, CFG_SHOW_ENDS, 1'b0, ""},
			'{ROW_CFG, 8'h00, CFG_SHOW_TABS, 1'b0, ""},
			'{ROW_CFG, 8'h00, CFG_SHOW_NONPRINTING, 1'b0, ""},
			'{ROW_BYTE, 8'h0a, '0, 1'b1, "\n"},
			'{ROW_BYTE, 8'h0a, '0, 1'b1, "\n"},
			'{ROW_BYTE, 8'h78, '0, 1'b0, ""},
			'{ROW_BYTE, 8'h09, '0, 1'b1, "\t"},
			'{ROW_BYTE, 8'h0a, '0, 1'b1, "\n"},
			// all off again
			'{ROW_CFG, 8'h00, CFG_NUMBER_ALL, 1'b0, ""},
			'{ROW_CFG, 8'h00, CFG_NUMBER_NONBLANK, 1'b0, ""},
			'{ROW_BYTE, 8'h7a, '0, 1'b1, "z"}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		prev_cfg = 1'b0;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				if (!prev_cfg)
					wait_idle();
				write_reg(dir_rows[i].idx, dir_rows[i].value[0]);
				prev_cfg = 1'b1;
			end else begin
				if (prev_cfg)
					cfg_valid <= 1'b0;
				send_byte(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].txt);
				prev_cfg = 1'b0;
			end
		end

		// random phases, each with its own settings and idling
		phase = 0;
		while (text_sent < RandItems) begin
			wait_idle();
			if (phase == 0)
				phase_bits = '1;
			else if (phase == 1)
				phase_bits = '0;
			else
				phase_bits = NumRegs'($urandom);
			for (int r = 0; r <= CFG_SHOW_NONPRINTING; r++)
				write_reg(CfgIdxW'(r), phase_bits[r]);
			if ($urandom_range(0, 3) == 0)
				write_reg(CfgIdxW'($urandom_range(CfgSpareLo, CfgSpareHi)), 1'($urandom));
			cfg_valid <= 1'b0;
			tx_gap_max = (phase == 0 || $urandom_range(0, 3) == 0) ? 0 : 3;
			rx_gap_max = (phase == 0 || $urandom_range(0, 3) == 0) ? 0 : 3;
			target = text_sent + PhaseItems;
			while (text_sent < target)
				send_line();
			phase++;
		end

		wait_idle();
		if (err_count == 0)
			$display("text_line_number_escape_filter_core_tb: clean");
		else
			$display("text_line_number_escape_filter_core_tb: errors");
		$finish;
	end

endmodule
